/* rtl/core/pqsc_pkg.sv */
`timescale 1ns / 1ps

package pqsc_pkg;

	// register map of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY = 2'd1;
	localparam logic [15:0] RATE_RESET = 16'd12800;

	// datapath widths
	localparam int MUL_AW = 34;
	localparam int MUL_BW = 33;
	localparam int PROD_W = MUL_AW + MUL_BW;
	localparam int ACC_W  = 96;
	localparam int TMP_W  = 58;

	localparam longint TWO32 = 64'sd4294967296;

	// 1/100 and 1/52.29578 in Q0.32
	localparam longint K_POS = (TWO32 + 100 / 2) / 100;
	localparam longint K_ANG = (64'sd100000 * TWO32 + 5229578 / 2) / 5229578;

	// one-step model, Q.32, columns x, theta, xdot, thetadot, volts
	localparam longint MODEL [4][5] = '{
		'{ TWO32,
		   (64'sd51281 * TWO32 + 64'sd100000000 / 2) / 64'sd100000000,
		   (64'sd17961 * TWO32 + 64'sd1000000 / 2) / 64'sd1000000,
		   (64'sd26781 * TWO32 + 64'sd10000000000 / 2) / 64'sd10000000000,
		   (64'sd3618 * TWO32 + 64'sd10000000 / 2) / 64'sd10000000 },
		'{ 64'sd0,
		   -((64'sd10056 * TWO32 + 64'sd10000 / 2) / 64'sd10000),
		   (64'sd46419 * TWO32 + 64'sd10000000 / 2) / 64'sd10000000,
		   -((64'sd20029 * TWO32 + 64'sd1000000 / 2) / 64'sd1000000),
		   -((64'sd82708 * TWO32 + 64'sd100000000 / 2) / 64'sd100000000) },
		'{ 64'sd0,
		   (64'sd49519 * TWO32 + 64'sd1000000 / 2) / 64'sd1000000,
		   (64'sd80322 * TWO32 + 64'sd100000 / 2) / 64'sd100000,
		   (64'sd43546 * TWO32 + 64'sd100000000 / 2) / 64'sd100000000,
		   (64'sd34913 * TWO32 + 64'sd1000000 / 2) / 64'sd1000000 },
		'{ 64'sd0,
		   -((64'sd55967 * TWO32 + 64'sd100000 / 2) / 64'sd100000),
		   (64'sd44824 * TWO32 + 64'sd100000 / 2) / 64'sd100000,
		   -((64'sd10048 * TWO32 + 64'sd10000 / 2) / 64'sd10000),
		   -((64'sd79879 * TWO32 + 64'sd1000000 / 2) / 64'sd1000000) }
	};

	// symmetric weight matrix, Q.16
	localparam longint PMAT [4][4] = '{
		'{ (64'sd3762 * 65536 + 50) / 100, (64'sd5822 * 65536 + 50) / 100,
		   (64'sd1787 * 65536 + 50) / 100, (64'sd1161 * 65536 + 50) / 100 },
		'{ (64'sd5822 * 65536 + 50) / 100, (64'sd31316 * 65536 + 50) / 100,
		   (64'sd6936 * 65536 + 50) / 100, (64'sd5609 * 65536 + 50) / 100 },
		'{ (64'sd1787 * 65536 + 50) / 100, (64'sd6936 * 65536 + 50) / 100,
		   (64'sd2981 * 65536 + 50) / 100, (64'sd1481 * 65536 + 50) / 100 },
		'{ (64'sd1161 * 65536 + 50) / 100, (64'sd5609 * 65536 + 50) / 100,
		   (64'sd1481 * 65536 + 50) / 100, (64'sd1204 * 65536 + 50) / 100 }
	};

	typedef enum logic [2:0] {
		A_KPOS,
		A_KANG,
		A_RATE,
		A_COEF,
		A_PMAT,
		A_XA
	} a_sel_t;

	typedef enum logic [2:0] {
		B_TRACK,
		B_ANGLE,
		B_DPOS,
		B_DANG,
		B_STATE,
		B_XA,
		B_TLO,
		B_THI
	} b_sel_t;

	typedef enum logic [2:0] {
		D_NONE,
		D_POS,
		D_ANG,
		D_VPOS,
		D_VANG,
		D_XA,
		D_TMP,
		D_ENERGY
	} dest_t;

	typedef struct packed {
		logic   capture;
		logic   issue;
		a_sel_t a_sel;
		b_sel_t b_sel;
		logic [1:0] row;
		logic [2:0] col;
		logic   first;
		logic   last;
		logic   hi;
		dest_t  dest;
		logic   out_load;
	} pqsc_cmd_t;

	typedef struct packed {
		logic out_free;
	} pqsc_sts_t;

endpackage

/* rtl/core/pqsc_ctrl.sv */
`timescale 1ns / 1ps

module pqsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  pqsc_pkg::pqsc_sts_t  sts,
	output pqsc_pkg::pqsc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_VEL,
		ST_PROJ,
		ST_QUAD,
		ST_ENER,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t     state_q;
	state_t     after_q;
	state_t     next_phase;
	logic       wait_q;
	logic [1:0] row_q;
	logic [2:0] col_q;
	logic       col_last;
	logic       multi_row;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		col_last   = 1'b0;
		multi_row  = 1'b0;
		next_phase = ST_DONE;
		unique case (state_q)
			ST_POS: begin
				col_last   = (col_q == 3'd1);
				next_phase = ST_VEL;
			end
			ST_VEL: begin
				col_last   = (col_q == 3'd1);
				next_phase = ST_PROJ;
			end
			ST_PROJ: begin
				col_last   = (col_q == 3'd4);
				multi_row  = 1'b1;
				next_phase = ST_QUAD;
			end
			ST_QUAD: begin
				col_last   = (col_q == 3'd3);
				multi_row  = 1'b1;
				next_phase = ST_ENER;
			end
			ST_ENER: begin
				col_last   = (col_q == 3'd1);
				multi_row  = 1'b1;
				next_phase = ST_DONE;
			end
			default: begin
				col_last   = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.row   = row_q;
		cmd.col   = col_q;
		cmd.a_sel = pqsc_pkg::A_KPOS;
		cmd.b_sel = pqsc_pkg::B_TRACK;
		cmd.dest  = pqsc_pkg::D_NONE;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = s_axis_tvalid;
			end
			ST_POS: begin
				cmd.issue = 1'b1;
				cmd.first = 1'b1;
				cmd.last  = 1'b1;
				cmd.a_sel = col_q[0] ? pqsc_pkg::A_KANG : pqsc_pkg::A_KPOS;
				cmd.b_sel = col_q[0] ? pqsc_pkg::B_ANGLE : pqsc_pkg::B_TRACK;
				cmd.dest  = col_q[0] ? pqsc_pkg::D_ANG : pqsc_pkg::D_POS;
			end
			ST_VEL: begin
				cmd.issue = 1'b1;
				cmd.first = 1'b1;
				cmd.last  = 1'b1;
				cmd.a_sel = pqsc_pkg::A_RATE;
				cmd.b_sel = col_q[0] ? pqsc_pkg::B_DANG : pqsc_pkg::B_DPOS;
				cmd.dest  = col_q[0] ? pqsc_pkg::D_VANG : pqsc_pkg::D_VPOS;
			end
			ST_PROJ: begin
				cmd.issue = 1'b1;
				cmd.first = (col_q == 3'd0);
				cmd.last  = col_last;
				cmd.a_sel = pqsc_pkg::A_COEF;
				cmd.b_sel = pqsc_pkg::B_STATE;
				cmd.dest  = pqsc_pkg::D_XA;
			end
			ST_QUAD: begin
				cmd.issue = 1'b1;
				cmd.first = (col_q == 3'd0);
				cmd.last  = col_last;
				cmd.a_sel = pqsc_pkg::A_PMAT;
				cmd.b_sel = pqsc_pkg::B_XA;
				cmd.dest  = pqsc_pkg::D_TMP;
			end
			ST_ENER: begin
				// low then high half of each row product, one running sum
				cmd.issue = 1'b1;
				cmd.first = (row_q == 2'd0) && (col_q == 3'd0);
				cmd.last  = (row_q == 2'd3) && col_last;
				cmd.hi    = col_q[0];
				cmd.a_sel = pqsc_pkg::A_XA;
				cmd.b_sel = col_q[0] ? pqsc_pkg::B_THI : pqsc_pkg::B_TLO;
				cmd.dest  = pqsc_pkg::D_ENERGY;
			end
			ST_WAIT: begin
				cmd.issue = 1'b0;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= ST_IDLE;
			wait_q  <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					if (s_axis_tvalid) begin
						state_q <= ST_POS;
					end
				end
				ST_POS, ST_VEL, ST_PROJ, ST_QUAD, ST_ENER: begin
					if (col_last) begin
						col_q <= '0;
						if (!multi_row || row_q == 2'd3) begin
							// wait for the last sum to reach its register
							row_q   <= '0;
							wait_q  <= 1'b1;
							after_q <= next_phase;
							state_q <= ST_WAIT;
						end else begin
							row_q <= row_q + 2'd1;
						end
					end else begin
						col_q <= col_q + 3'd1;
					end
				end
				ST_WAIT: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						state_q <= after_q;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/core/pqsc_dp.sv */
`timescale 1ns / 1ps

module pqsc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [pqsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                          cfg_data,
	input  logic                                 s_axis_tuser,
	input  logic [95:0]                          s_axis_tdata,
	input  logic                                 m_axis_tready,
	output logic                                 m_axis_tvalid,
	output logic [47:0]                          m_axis_tdata,
	output logic                                 m_axis_tuser,
	input  pqsc_pkg::pqsc_cmd_t                  cmd,
	output pqsc_pkg::pqsc_sts_t                  sts
);

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} clip32_t;

	typedef struct packed {
		logic               sat;
		logic signed [47:0] val;
	} clip48_t;

	function automatic clip32_t clip32(input logic signed [pqsc_pkg::ACC_W-1:0] v);
		clip32_t r;
		logic [pqsc_pkg::ACC_W-32:0] top;
		top   = v[pqsc_pkg::ACC_W-1:31];
		r.sat = !((&top) || (~|top));
		if (r.sat) begin
			r.val = v[pqsc_pkg::ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r.val = v[31:0];
		end
		return r;
	endfunction

	function automatic clip48_t clip48(input logic signed [pqsc_pkg::ACC_W-1:0] v);
		clip48_t r;
		logic [pqsc_pkg::ACC_W-48:0] top;
		top   = v[pqsc_pkg::ACC_W-1:47];
		r.sat = !((&top) || (~|top));
		if (r.sat) begin
			r.val = v[pqsc_pkg::ACC_W-1] ? 48'sh800000000000 : 48'sh7fffffffffff;
		end else begin
			r.val = v[47:0];
		end
		return r;
	endfunction

	logic [15:0] primary_rate_q;
	logic [15:0] secondary_rate_q;

	logic               op_q;
	logic signed [31:0] ang_q;
	logic signed [31:0] trk_q;
	logic signed [31:0] drv_q;
	logic signed [31:0] last_pos_q;
	logic signed [31:0] last_ang_q;

	// x, theta, xdot, thetadot; volts come straight from drv_q
	logic signed [31:0] vec_q [4];
	logic signed [31:0] xa_q  [4];
	logic signed [pqsc_pkg::TMP_W-1:0] tmp_q [4];
	logic signed [47:0] energy_q;
	logic               sat_q;

	logic signed [pqsc_pkg::MUL_AW-1:0] a_op;
	logic signed [pqsc_pkg::MUL_BW-1:0] b_op;
	logic signed [32:0] dpos;
	logic signed [32:0] dang;
	logic [15:0]        rate;

	logic signed [pqsc_pkg::PROD_W-1:0] prod_s1;
	logic               v_s1;
	logic               first_s1;
	logic               last_s1;
	logic               hi_s1;
	pqsc_pkg::dest_t    dest_s1;
	logic [1:0]         row_s1;

	logic signed [pqsc_pkg::ACC_W-1:0] acc_q;
	logic signed [pqsc_pkg::ACC_W-1:0] addend;
	logic signed [pqsc_pkg::ACC_W-1:0] bias;
	logic               wb_s2;
	pqsc_pkg::dest_t    dest_s2;
	logic [1:0]         row_s2;

	clip32_t c_vel;
	clip32_t c_xa;
	clip48_t c_en;

	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;
	logic               m_tuser_q;

	assign rate = op_q ? secondary_rate_q : primary_rate_q;
	assign dpos = 33'(vec_q[0]) - 33'(last_pos_q);
	assign dang = 33'(vec_q[1]) - 33'(last_ang_q);

	always_comb begin
		unique case (cmd.a_sel)
			pqsc_pkg::A_KPOS: a_op = pqsc_pkg::MUL_AW'(pqsc_pkg::K_POS);
			pqsc_pkg::A_KANG: a_op = pqsc_pkg::MUL_AW'(pqsc_pkg::K_ANG);
			pqsc_pkg::A_RATE: a_op = pqsc_pkg::MUL_AW'(rate);
			pqsc_pkg::A_COEF: a_op = pqsc_pkg::MUL_AW'(pqsc_pkg::MODEL[cmd.row][cmd.col]);
			pqsc_pkg::A_PMAT: a_op = pqsc_pkg::MUL_AW'(pqsc_pkg::PMAT[cmd.row][cmd.col[1:0]]);
			pqsc_pkg::A_XA:   a_op = pqsc_pkg::MUL_AW'(xa_q[cmd.row]);
			default:          a_op = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.b_sel)
			pqsc_pkg::B_TRACK: b_op = pqsc_pkg::MUL_BW'(trk_q);
			pqsc_pkg::B_ANGLE: b_op = pqsc_pkg::MUL_BW'(ang_q);
			pqsc_pkg::B_DPOS:  b_op = pqsc_pkg::MUL_BW'(dpos);
			pqsc_pkg::B_DANG:  b_op = pqsc_pkg::MUL_BW'(dang);
			pqsc_pkg::B_STATE: begin
				b_op = (cmd.col == 3'd4) ? pqsc_pkg::MUL_BW'(drv_q)
				                         : pqsc_pkg::MUL_BW'(vec_q[cmd.col[1:0]]);
			end
			pqsc_pkg::B_XA:    b_op = pqsc_pkg::MUL_BW'(xa_q[cmd.col[1:0]]);
			// row sum split so each product stays within the multiplier
			pqsc_pkg::B_TLO:   b_op = $signed({1'b0, tmp_q[cmd.row][31:0]});
			pqsc_pkg::B_THI:   b_op = pqsc_pkg::MUL_BW'($signed(tmp_q[cmd.row][pqsc_pkg::TMP_W-1:32]));
		endcase
	end

	// round half up: bias added once at the start of each rounded sum; tmp sums take none
	always_comb begin
		unique case (dest_s1)
			pqsc_pkg::D_POS, pqsc_pkg::D_ANG, pqsc_pkg::D_XA:
				bias = pqsc_pkg::ACC_W'(1) <<< 31;
			pqsc_pkg::D_VPOS, pqsc_pkg::D_VANG:
				bias = pqsc_pkg::ACC_W'(1) <<< 7;
			pqsc_pkg::D_ENERGY:
				bias = pqsc_pkg::ACC_W'(1) <<< 23;
			default:
				bias = '0;
		endcase
	end

	assign addend = hi_s1 ? (pqsc_pkg::ACC_W'(prod_s1) <<< 32) : pqsc_pkg::ACC_W'(prod_s1);

	assign c_vel = clip32(acc_q >>> 8);
	assign c_xa  = clip32(acc_q >>> 32);
	assign c_en  = clip48(acc_q >>> 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_rate_q   <= pqsc_pkg::RATE_RESET;
			secondary_rate_q <= pqsc_pkg::RATE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == pqsc_pkg::CFG_PRIMARY) begin
				primary_rate_q <= cfg_data;
			end else if (cfg_index == pqsc_pkg::CFG_SECONDARY) begin
				secondary_rate_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			hi_s1      <= 1'b0;
			dest_s1    <= pqsc_pkg::D_NONE;
			row_s1     <= '0;
			wb_s2      <= 1'b0;
			dest_s2    <= pqsc_pkg::D_NONE;
			row_s2     <= '0;
			last_pos_q <= '0;
			last_ang_q <= '0;
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1     <= cmd.issue;
			first_s1 <= cmd.first;
			last_s1  <= cmd.issue && cmd.last;
			hi_s1    <= cmd.hi;
			dest_s1  <= cmd.dest;
			row_s1   <= cmd.row;
			wb_s2    <= v_s1 && last_s1;
			dest_s2  <= dest_s1;
			row_s2   <= row_s1;

			if (cmd.capture) begin
				sat_q <= 1'b0;
			end else if (wb_s2) begin
				unique case (dest_s2)
					pqsc_pkg::D_VPOS: begin
						last_pos_q <= vec_q[0];
						sat_q      <= sat_q | c_vel.sat;
					end
					pqsc_pkg::D_VANG: begin
						last_ang_q <= vec_q[1];
						sat_q      <= sat_q | c_vel.sat;
					end
					pqsc_pkg::D_XA:     sat_q <= sat_q | c_xa.sat;
					pqsc_pkg::D_ENERGY: sat_q <= sat_q | c_en.sat;
					default:            sat_q <= sat_q;
				endcase
			end

			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= s_axis_tuser;
			ang_q <= s_axis_tdata[31:0];
			trk_q <= s_axis_tdata[63:32];
			drv_q <= s_axis_tdata[95:64];
		end

		if (cmd.issue) begin
			prod_s1 <= a_op * b_op;
		end

		if (v_s1) begin
			acc_q <= first_s1 ? (bias + addend) : (acc_q + addend);
		end

		if (wb_s2) begin
			unique case (dest_s2)
				pqsc_pkg::D_POS:    vec_q[0]       <= acc_q[63:32];
				pqsc_pkg::D_ANG:    vec_q[1]       <= acc_q[63:32];
				pqsc_pkg::D_VPOS:   vec_q[2]       <= c_vel.val;
				pqsc_pkg::D_VANG:   vec_q[3]       <= c_vel.val;
				pqsc_pkg::D_XA:     xa_q[row_s2]   <= c_xa.val;
				pqsc_pkg::D_TMP:    tmp_q[row_s2]  <= acc_q[pqsc_pkg::TMP_W-1:0];
				pqsc_pkg::D_ENERGY: energy_q       <= c_en.val;
				default:            energy_q       <= energy_q;
			endcase
		end

		if (cmd.out_load) begin
			m_tdata_q <= energy_q;
			m_tuser_q <= sat_q;
		end
	end

	assign sts.out_free  = !m_tvalid_q || m_axis_tready;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_axis_tready))
		else $error("result loaded over a beat not yet taken");

	a_sum_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !first_s1) |-> $past(v_s1 && !last_s1))
		else $error("accumulation continued across a closed sum");

	a_capture_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!v_s1 && !wb_s2))
		else $error("new sample taken while the pipeline is busy");

endmodule

/* rtl/core/projected_quadratic_safety_check.sv */
`timescale 1ns / 1ps

// Cart-pole safety energy. Each input beat carries the pendulum angle, the cart
// position and the drive voltage (signed Q16.16); tuser picks the primary (0) or
// secondary (1) sample rate, both written over the cfg port (index 0 and 1,
// unsigned Q8.8, reset 50.0). The block scales position and angle, forms the
// velocities against the previous sample, projects the state one step with the
// fixed model and returns xa'*P*xa as signed Q24.24 on m_axis_tdata, with
// m_axis_tuser set when the energy or any velocity or projected element was
// clipped. The result goes to the output register and s_axis_tready is high again
// in the next cycle; a new sample is not accepted before then, as all 48
// multiplies go through one shared 34x33 multiply-accumulate unit, with a drain
// after each of the five steps so the next step sees the previous step's results.
// The next sample is accepted while a result still waits; a result not taken
// holds the block before its next output.
module projected_quadratic_safety_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pqsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [95:0]                    s_axis_tdata,  // angle_deg, track_cm, drive_volts
	input  logic                           s_axis_tuser,  // operation
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [47:0]                    m_axis_tdata,  // energy
	output logic                           m_axis_tuser   // saturated
);

	pqsc_pkg::pqsc_cmd_t cmd;
	pqsc_pkg::pqsc_sts_t sts;

	assign cfg_ready = 1'b1;

	pqsc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	pqsc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam logic OP_PRIMARY   = 1'b0;
	localparam logic OP_SECONDARY = 1'b1;

	// indexes outside the register map, writes there must change nothing
	localparam logic [pqsc_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd2;
	localparam logic [pqsc_pkg::CFG_IDX_W-1:0] CFG_SPARE_TOP = 2'd3;

	localparam logic [15:0] RATE_AT_RESET = 16'd12800;
	localparam longint TWO_POW_32 = 64'sd4294967296;
	localparam longint K_POS_Q32 = (TWO_POW_32 + 64'sd50) / 64'sd100;
	localparam longint K_ANG_Q32 = (64'sd100000 * TWO_POW_32 + 64'sd2614789) / 64'sd5229578;
	localparam int HOLD_CYCLES = 600;

	typedef struct packed {
		logic [47:0] energy;
		logic        saturated;
	} energy_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pqsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;  // angle_deg, track_cm, drive_volts
	logic s_axis_tuser = 1'b0;       // operation
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // energy
	logic m_axis_tuser;              // saturated

	// predictor copy of the block state and rates
	logic [15:0] rate_primary = RATE_AT_RESET;
	logic [15:0] rate_secondary = RATE_AT_RESET;
	logic signed [31:0] last_pos = '0;
	logic signed [31:0] last_ang = '0;

	energy_t energy_q[$];
	energy_t head;
	int mismatch_count = 0;

	bit source_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	bit hold_output = 1'b0;
	logic signed [31:0] walk_angle = '0;
	logic signed [31:0] walk_track = '0;

	projected_quadratic_safety_check i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint q32(input longint n, input longint d);
		return (n * TWO_POW_32 + d / 2) / d;
	endfunction

	// projection coefficients, columns x, theta, xdot, thetadot, volts
	function automatic longint model_coef(input int row, input int col);
		case (row)
			0: begin
				case (col)
					0: return q32(1, 1);
					1: return q32(51281, 100000000);
					2: return q32(17961, 1000000);
					3: return q32(26781, 64'sd10000000000);
					4: return q32(3618, 10000000);
					default: return 64'sd0;
				endcase
			end
			1: begin
				case (col)
					1: return -q32(10056, 10000);
					2: return q32(46419, 10000000);
					3: return -q32(20029, 1000000);
					4: return -q32(82708, 100000000);
					default: return 64'sd0;
				endcase
			end
			2: begin
				case (col)
					1: return q32(49519, 1000000);
					2: return q32(80322, 100000);
					3: return q32(43546, 100000000);
					4: return q32(34913, 1000000);
					default: return 64'sd0;
				endcase
			end
			3: begin
				case (col)
					1: return -q32(55967, 100000);
					2: return q32(44824, 100000);
					3: return -q32(10048, 10000);
					4: return -q32(79879, 1000000);
					default: return 64'sd0;
				endcase
			end
			default: return 64'sd0;
		endcase
	endfunction

	// symmetric weight matrix in Q.16, upper triangle in hundredths
	function automatic longint weight(input int row, input int col);
		longint hundredths;
		int lo_i, hi_i;
		lo_i = row < col ? row : col;
		hi_i = row < col ? col : row;
		case (lo_i * 4 + hi_i)
			0: hundredths = 3762;
			1: hundredths = 5822;
			2: hundredths = 1787;
			3: hundredths = 1161;
			5: hundredths = 31316;
			6: hundredths = 6936;
			7: hundredths = 5609;
			10: hundredths = 2981;
			11: hundredths = 1481;
			default: hundredths = 1204;
		endcase
		return (hundredths * 65536 + 50) / 100;
	endfunction

	// round half up by 2^k
	function automatic logic signed [127:0] rnd(input logic signed [127:0] v, input int k);
		return (v + (128'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic logic signed [127:0] clip(input logic signed [127:0] v, input int w);
		logic signed [127:0] top, bottom;
		top = (128'sd1 <<< (w - 1)) - 128'sd1;
		bottom = -(128'sd1 <<< (w - 1));
		if (v > top)
			return top;
		if (v < bottom)
			return bottom;
		return v;
	endfunction

	task automatic predict_energy(input logic op, input logic signed [31:0] angle,
		input logic signed [31:0] track, input logic signed [31:0] volts);
		logic signed [127:0] st [5];
		logic signed [127:0] xa [4];
		logic signed [127:0] wsum [4];
		logic signed [127:0] acc, rounded, held, rate;
		logic sat;
		energy_t res;
		int i, j;
		sat = 1'b0;
		rate = 128'((op == OP_SECONDARY) ? rate_secondary : rate_primary);
		acc = 128'(track);
		acc = acc * K_POS_Q32;
		st[0] = rnd(acc, 32);
		acc = 128'(angle);
		acc = acc * K_ANG_Q32;
		st[1] = rnd(acc, 32);
		acc = st[0] - last_pos;
		rounded = rnd(acc * rate, 8);
		held = clip(rounded, 32);
		sat |= held != rounded;
		st[2] = held;
		acc = st[1] - last_ang;
		rounded = rnd(acc * rate, 8);
		held = clip(rounded, 32);
		sat |= held != rounded;
		st[3] = held;
		st[4] = 128'(volts);
		last_pos = st[0][31:0];
		last_ang = st[1][31:0];
		for (i = 0; i < 4; i++) begin
			acc = '0;
			for (j = 0; j < 5; j++)
				acc = acc + model_coef(i, j) * st[j];
			rounded = rnd(acc, 32);
			held = clip(rounded, 32);
			sat |= held != rounded;
			xa[i] = held;
		end
		for (i = 0; i < 4; i++) begin
			acc = '0;
			for (j = 0; j < 4; j++)
				acc = acc + weight(i, j) * xa[j];
			wsum[i] = acc;
		end
		acc = '0;
		for (i = 0; i < 4; i++)
			acc = acc + xa[i] * wsum[i];
		rounded = rnd(acc, 24);
		held = clip(rounded, 48);
		sat |= held != rounded;
		res.energy = held[47:0];
		res.saturated = sat;
		energy_q.push_back(res);
	endtask

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 4);
		return $urandom_range(20, 100);
	endfunction

	function automatic logic [31:0] spread(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic signed [31:0] drift(input logic signed [31:0] p);
		if (p > 32'sd3000000 || p < -32'sd3000000)
			return p >>> 1;
		return p + spread(8192);
	endfunction

	function automatic logic [15:0] pick_rate();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'd1;
		if (r < 30)
			return 16'hffff;
		if (r < 38)
			return 16'd0;
		return 16'($urandom_range(1, 65535));
	endfunction

	// leaves tvalid high so a following beat can go out back to back
	task automatic send_sample(input logic op, input logic [31:0] angle, input logic [31:0] track,
		input logic [31:0] volts);
		int gap;
		gap = (source_idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {volts, track, angle};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_energy(op, angle, track, volts);
	endtask

	task automatic send_random(input int walk_pct);
		int r;
		logic op;
		logic [31:0] a, t, v;
		r = $urandom_range(0, 99);
		op = ($urandom_range(0, 1) == 1) ? OP_SECONDARY : OP_PRIMARY;
		if (r < walk_pct) begin
			walk_angle = drift(walk_angle);
			walk_track = drift(walk_track);
			a = walk_angle;
			t = walk_track;
			v = spread(12 << 16);
		end else if (r < walk_pct + (100 - walk_pct) / 2) begin
			a = spread(30 << 16);
			t = spread(200 << 16);
			v = spread(24 << 16);
		end else begin
			a = $urandom;
			t = $urandom;
			v = $urandom;
		end
		send_sample(op, a, t, v);
	endtask

	// stops the stream and waits for every pending result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (energy_q.size() != 0);
	endtask

	// leaves cfg_valid high, the caller lowers it after the last write
	task automatic write_reg(input logic [pqsc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == pqsc_pkg::CFG_PRIMARY)
			rate_primary = value;
		else if (idx == pqsc_pkg::CFG_SECONDARY)
			rate_secondary = value;
	endtask

	task automatic program_rates(input logic [15:0] pri, input logic [15:0] sec);
		write_reg(pqsc_pkg::CFG_PRIMARY, pri);
		write_reg(pqsc_pkg::CFG_SECONDARY, sec);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_first_sample();
		// previous position and angle are still zero here
		send_sample(OP_PRIMARY, 32'h0005_0000, 32'h000a_0000, 32'h0002_0000);
		send_sample(OP_SECONDARY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
	endtask

	task automatic test_field_extremes();
		send_sample(OP_PRIMARY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_sample(OP_SECONDARY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_sample(OP_PRIMARY, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
		send_sample(OP_SECONDARY, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		send_sample(OP_PRIMARY, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
		send_sample(OP_PRIMARY, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
		// half-lsb values exercise the rounding
		send_sample(OP_SECONDARY, 32'h0000_8000, 32'hffff_8000, 32'h0001_0000);
	endtask

	task automatic test_unknown_index();
		drain_results();
		write_reg(CFG_SPARE, 16'h0000);
		write_reg(CFG_SPARE_TOP, 16'hffff);
		cfg_valid <= 1'b0;
		send_sample(OP_PRIMARY, 32'h0003_0000, 32'hfff0_0000, 32'h0001_8000);
		send_sample(OP_SECONDARY, 32'h0002_0000, 32'hffe8_0000, 32'hfffe_0000);
	endtask

	task automatic test_rate_extremes();
		drain_results();
		// zero rate, velocities must come out zero
		program_rates(16'd0, 16'd0);
		send_sample(OP_PRIMARY, 32'h0004_0000, 32'h0020_0000, 32'h0001_0000);
		send_sample(OP_SECONDARY, 32'hfffc_0000, 32'hffd0_0000, 32'h0000_0000);
		drain_results();
		program_rates(16'hffff, 16'd1);
		// a huge jump clips the velocity
		send_sample(OP_PRIMARY, 32'h4000_0000, 32'h4000_0000, 32'h0000_0000);
		send_sample(OP_PRIMARY, 32'hc000_0000, 32'hc000_0000, 32'h0000_0000);
		send_sample(OP_SECONDARY, 32'h0001_0000, 32'h0001_0000, 32'h0000_4000);
		send_sample(OP_SECONDARY, 32'h0001_8000, 32'h0000_c000, 32'hffff_c000);
		drain_results();
		program_rates(RATE_AT_RESET, 16'd25600);
		send_sample(OP_PRIMARY, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000);
		send_sample(OP_SECONDARY, 32'h0001_4000, 32'h0002_4000, 32'h0000_8000);
	endtask

	task automatic test_trajectories();
		int phase;
		for (phase = 0; phase < 8; phase++) begin
			drain_results();
			program_rates(pick_rate(), pick_rate());
			repeat (150) send_random(80);
		end
	endtask

	task automatic test_output_hold();
		// sink holds off while the source keeps offering, input must stall
		source_idle_on = 1'b0;
		hold_output = 1'b1;
		repeat (60) send_random(80);
		source_idle_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		source_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (150) send_random(80);
		source_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	task automatic test_noise();
		drain_results();
		program_rates(pick_rate(), pick_rate());
		repeat (150) send_random(0);
	endtask

	// sink side: one assignment of tready per stretch
	initial begin
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (sink_idle_on && $urandom_range(0, 99) < 30) begin
				m_axis_tready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (energy_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: energy %h saturated %b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				head = energy_q.pop_front();
				if (m_axis_tdata !== head.energy || m_axis_tuser !== head.saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected energy %h saturated %b, got %h %b",
							head.energy, head.saturated, m_axis_tdata, m_axis_tuser);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_sample();
		test_field_extremes();
		test_unknown_index();
		test_rate_extremes();
		test_trajectories();
		test_output_hold();
		test_steady_stream();
		test_noise();
		drain_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/core/pqsc_pkg.sv
rtl/core/pqsc_ctrl.sv
rtl/core/pqsc_dp.sv
rtl/core/projected_quadratic_safety_check.sv
bench/tb_top.sv
